// ----- rtl/spq_pkg.sv -----
// spq_pkg: shared opcodes and control types for the stable min priority queue.
// No dependencies.
package spq_pkg;

	localparam int OP_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ   = 2'd0,
		OP_DEQ   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic ins;
		logic del;
	} ctl_t;

endpackage

// ----- rtl/spq_ifs.sv -----
// spq_req_if and spq_rsp_if: valid/ready channels for requests and results.
// Depends on spq_pkg.
interface spq_req_if import spq_pkg::*; #(
	parameter int PRIO_W = 16,
	parameter int TAG_W  = 16
);
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [TAG_W-1:0]  payload;
	logic [PRIO_W-1:0] priority_req;

	modport source (output valid, opcode, payload, priority_req, input ready);
	modport sink   (input valid, opcode, payload, priority_req, output ready);
endinterface

interface spq_rsp_if #(
	parameter int PRIO_W = 16,
	parameter int TAG_W  = 16,
	parameter int CNT_W  = 5
);
	logic              valid;
	logic              ready;
	logic [TAG_W-1:0]  popped_payload;
	logic              popped_valid;
	logic [CNT_W-1:0]  entry_count;
	logic              is_empty;
	logic [PRIO_W-1:0] front_priority;
	logic              overflow;

	modport source (output valid, popped_payload, popped_valid, entry_count, is_empty,
		front_priority, overflow, input ready);
	modport sink   (input valid, popped_payload, popped_valid, entry_count, is_empty,
		front_priority, overflow, output ready);
endinterface

// ----- rtl/spq_cell.sv -----
// spq_cell: one slot of the sorted row; compares against the broadcast priority
// and takes its own, the new, the left or the right entry. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
	parameter int PRIO_W = 16,
	parameter int TAG_W  = 16
) (
	input  logic              clk,
	input  ctl_t              ctl,
	input  logic [PRIO_W-1:0] new_prio,
	input  logic [TAG_W-1:0]  new_tag,
	input  logic              own_valid,
	input  logic              left_le,
	input  logic [PRIO_W-1:0] left_prio,
	input  logic [TAG_W-1:0]  left_tag,
	input  logic [PRIO_W-1:0] right_prio,
	input  logic [TAG_W-1:0]  right_tag,
	output logic              le,
	output logic [PRIO_W-1:0] prio,
	output logic [TAG_W-1:0]  tag
);

	logic [PRIO_W-1:0] prio_q, prio_d;
	logic [TAG_W-1:0]  tag_q, tag_d;

	// entry stays put on insert: equal priorities keep arrival order
	assign le = own_valid && (prio_q <= new_prio);

	always_comb begin
		prio_d = prio_q;
		tag_d  = tag_q;
		if (ctl.ins) begin
			if (!le) begin
				if (left_le) begin
					prio_d = new_prio;
					tag_d  = new_tag;
				end else begin
					prio_d = left_prio;
					tag_d  = left_tag;
				end
			end
		end else if (ctl.del) begin
			prio_d = right_prio;
			tag_d  = right_tag;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= prio_d;
		tag_q  <= tag_d;
	end

	assign prio = prio_q;
	assign tag  = tag_q;

endmodule

// ----- rtl/stable_min_priority_queue.sv -----
// Stable min priority queue: a row of CAPACITY cells kept sorted by priority, head in
// cell 0. One transaction is accepted every cycle; its result is registered and offered
// on the next cycle, and a new request is taken while that result waits, as long as
// the result register is free or being emptied in the same cycle. An enqueue
// broadcasts its priority to all cells; each compares once, and the cells holding a
// larger priority shift right by one cell, so neither insertion nor removal depends
// on the fill level. Equal priorities leave in arrival order; an enqueue into a full
// queue is dropped and flagged as overflow. Depends on spq_pkg, spq_ifs and spq_cell.
module stable_min_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY      = 16,
	parameter int PRIORITY_BITS = 16,
	parameter int PAYLOAD_BITS  = 16
) (
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]         count_q, count_d;
	logic                     fire;
	logic                     is_enq, is_deq, full, nonempty;
	ctl_t                     ctl;
	logic [CAPACITY-1:0]      cell_valid, cell_le;
	logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
	logic [PAYLOAD_BITS-1:0]  cell_tag  [CAPACITY];

	logic                     rsp_valid_q;
	logic [PAYLOAD_BITS-1:0]  pop_tag_q, pop_tag_d;
	logic                     pop_valid_q, pop_valid_d;
	logic [CNT_W-1:0]         cnt_out_q;
	logic                     empty_q;
	logic [PRIORITY_BITS-1:0] front_q, front_d;
	logic                     ovf_q, ovf_d;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign full      = (count_q == CAP_CNT);
	assign nonempty  = (count_q != '0);

	always_comb begin
		is_enq = 1'b0;
		is_deq = 1'b0;
		unique case (req.opcode)
			OP_ENQ:  is_enq = 1'b1;
			OP_DEQ:  is_deq = 1'b1;
			default: ;
		endcase
	end

	assign ctl.ins = fire && is_enq && !full;
	assign ctl.del = fire && is_deq && nonempty;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic                     l_le;
			logic [PRIORITY_BITS-1:0] l_prio, r_prio;
			logic [PAYLOAD_BITS-1:0]  l_tag, r_tag;

			assign cell_valid[i] = (CNT_W'(i) < count_q);

			if (i == 0) begin : g_head
				assign l_le   = 1'b1;
				assign l_prio = req.priority_req;
				assign l_tag  = req.payload;
			end else begin : g_body
				assign l_le   = cell_le[i-1];
				assign l_prio = cell_prio[i-1];
				assign l_tag  = cell_tag[i-1];
			end

			if (i == CAPACITY - 1) begin : g_tail
				assign r_prio = cell_prio[i];
				assign r_tag  = cell_tag[i];
			end else begin : g_mid
				assign r_prio = cell_prio[i+1];
				assign r_tag  = cell_tag[i+1];
			end

			spq_cell #(
				.PRIO_W (PRIORITY_BITS),
				.TAG_W  (PAYLOAD_BITS)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.new_prio   (req.priority_req),
				.new_tag    (req.payload),
				.own_valid  (cell_valid[i]),
				.left_le    (l_le),
				.left_prio  (l_prio),
				.left_tag   (l_tag),
				.right_prio (r_prio),
				.right_tag  (r_tag),
				.le         (cell_le[i]),
				.prio       (cell_prio[i]),
				.tag        (cell_tag[i])
			);
		end
	endgenerate

	// result as seen after this transaction
	always_comb begin
		count_d     = count_q;
		pop_tag_d   = '0;
		pop_valid_d = 1'b0;
		ovf_d       = 1'b0;
		front_d     = nonempty ? cell_prio[0] : '0;
		if (ctl.ins) begin
			count_d = count_q + 1'b1;
			if (!nonempty || (req.priority_req < cell_prio[0]))
				front_d = req.priority_req;
		end else if (ctl.del) begin
			count_d     = count_q - 1'b1;
			pop_tag_d   = cell_tag[0];
			pop_valid_d = 1'b1;
			front_d     = (count_q > CNT_W'(1)) ? cell_prio[1] : '0;
		end else if (is_enq) begin
			ovf_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pop_tag_q   <= pop_tag_d;
			pop_valid_q <= pop_valid_d;
			cnt_out_q   <= count_d;
			empty_q     <= (count_d == '0);
			front_q     <= front_d;
			ovf_q       <= ovf_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.popped_payload = pop_tag_q;
	assign rsp.popped_valid   = pop_valid_q;
	assign rsp.entry_count    = cnt_out_q;
	assign rsp.is_empty       = empty_q;
	assign rsp.front_priority = front_q;
	assign rsp.overflow       = ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("occupancy above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow occupancy");

	a_empty_deq_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_deq && !nonempty |=> count_q == '0)
		else $error("dequeue on empty queue changed occupancy");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && ovf_q |-> cnt_out_q == CAP_CNT && !pop_valid_q)
		else $error("overflow flagged below capacity");

	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q > CNT_W'(1) |-> cell_prio[0] <= cell_prio[1])
		else $error("head cells out of order");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking testbench for stable_min_priority_queue, with a sorted shadow queue.
// Depends on spq_pkg, spq_ifs and the stable_min_priority_queue RTL.
module tb_top;
	import spq_pkg::*;

	localparam int CAPACITY = 16;
	localparam int PRIO_W   = 16;
	localparam int TAG_W    = 16;
	localparam int CNT_W    = 5;
	localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

	typedef struct packed {
		logic [TAG_W-1:0]  popped_payload;
		logic              popped_valid;
		logic [CNT_W-1:0]  entry_count;
		logic              is_empty;
		logic [PRIO_W-1:0] front_priority;
		logic              overflow;
	} status_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_req_if #(.PRIO_W(PRIO_W), .TAG_W(TAG_W)) req_ch ();
	spq_rsp_if #(.PRIO_W(PRIO_W), .TAG_W(TAG_W), .CNT_W(CNT_W)) rsp_ch ();

	stable_min_priority_queue #(
		.CAPACITY(CAPACITY),
		.PRIORITY_BITS(PRIO_W),
		.PAYLOAD_BITS(TAG_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic [PRIO_W-1:0] shadow_prio[$];
	logic [TAG_W-1:0]  shadow_tag[$];
	status_t           pending_status[$];
	status_t           got_status;
	status_t           want_status;
	int                n_mismatch = 0;
	bit                idle_en = 1'b1;
	int                stall_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// shadow of the sorted row: ties go behind every equal priority
	function automatic status_t queue_step(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
		logic [PRIO_W-1:0] prio);
		status_t s;
		int pos;
		s = '0;
		case (op)
			OP_ENQ: begin
				if (shadow_prio.size() >= CAPACITY) begin
					s.overflow = 1'b1;
				end else begin
					pos = 0;
					while (pos < shadow_prio.size() && shadow_prio[pos] <= prio)
						pos++;
					shadow_prio.insert(pos, prio);
					shadow_tag.insert(pos, tag);
				end
			end
			OP_DEQ: begin
				if (shadow_prio.size() > 0) begin
					s.popped_payload = shadow_tag.pop_front();
					void'(shadow_prio.pop_front());
					s.popped_valid = 1'b1;
				end
			end
			default: ;
		endcase
		s.entry_count    = CNT_W'(shadow_prio.size());
		s.is_empty       = (shadow_prio.size() == 0);
		s.front_priority = (shadow_prio.size() > 0) ? shadow_prio[0] : '0;
		return s;
	endfunction

	task automatic send_item(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
		logic [PRIO_W-1:0] prio);
		if (idle_en && $urandom_range(0, 9) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= op;
		req_ch.payload      <= tag;
		req_ch.priority_req <= prio;
		do @(posedge clk); while (!req_ch.ready);
		pending_status.push_back(queue_step(op, tag, prio));
	endtask

	function automatic logic [PRIO_W-1:0] pick_priority();
		case ($urandom_range(0, 3))
			0: return PRIO_W'($urandom_range(0, 7));
			1: return $urandom_range(0, 1) ? '1 : '0;
			default: return PRIO_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// response side: random stall bursts while idling is enabled
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_en && stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got_status.popped_payload = rsp_ch.popped_payload;
			got_status.popped_valid   = rsp_ch.popped_valid;
			got_status.entry_count    = rsp_ch.entry_count;
			got_status.is_empty       = rsp_ch.is_empty;
			got_status.front_priority = rsp_ch.front_priority;
			got_status.overflow       = rsp_ch.overflow;
			if (pending_status.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%0t: unexpected transaction %p", $realtime, got_status);
			end else begin
				want_status = pending_status.pop_front();
				if (got_status !== want_status) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("%0t: mismatch exp %p got %p", $realtime,
							want_status, got_status);
				end
			end
		end
	end

	task automatic test_empty_queue();
		send_item(OP_DEQ, 16'hBEEF, 16'h0001);
		send_item(OP_QUERY, 16'hFFFF, 16'hFFFF);
		send_item(OP_RSVD, 16'h1234, 16'h0000);
	endtask

	task automatic test_extremes_and_ties();
		send_item(OP_ENQ, 16'hFFFF, 16'hFFFF);
		send_item(OP_ENQ, 16'h0000, 16'h0000);
		send_item(OP_DEQ, 16'hFFFF, 16'hFFFF);
		send_item(OP_ENQ, 16'h1111, 16'h8000);
		send_item(OP_ENQ, 16'h2222, 16'h8000);
		send_item(OP_ENQ, 16'h3333, 16'h8000);
		send_item(OP_ENQ, 16'hAAAA, 16'h7FFF);
		send_item(OP_ENQ, 16'h5555, 16'hFFFF);
		send_item(OP_QUERY, 16'h0000, 16'h0000);
		repeat (7) send_item(OP_DEQ, 16'h0000, 16'h0000);
	endtask

	task automatic test_full_queue();
		while (shadow_prio.size() < CAPACITY)
			send_item(OP_ENQ, TAG_W'($urandom), pick_priority());
		repeat (2) send_item(OP_ENQ, TAG_W'($urandom), pick_priority());
		send_item(OP_RSVD, TAG_W'($urandom), PRIO_W'($urandom));
		while (shadow_prio.size() > 0)
			send_item(OP_DEQ, TAG_W'($urandom), PRIO_W'($urandom));
		send_item(OP_DEQ, TAG_W'($urandom), PRIO_W'($urandom));
	endtask

	task automatic test_random_mix(int n_items, int enq_pct, int deq_pct);
		int r;
		logic [OP_W-1:0] op;
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			if (r < enq_pct)
				op = OP_ENQ;
			else if (r < enq_pct + deq_pct)
				op = OP_DEQ;
			else
				op = r[0] ? OP_RSVD : OP_QUERY;
			send_item(op, TAG_W'($urandom), pick_priority());
		end
	endtask

	initial begin
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.opcode       <= OP_QUERY;
		req_ch.payload      <= '0;
		req_ch.priority_req <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_extremes_and_ties();
		test_full_queue();
		test_random_mix(400, 45, 45);
		test_random_mix(300, 70, 20);
		test_random_mix(300, 20, 70);
		test_random_mix(450, 48, 42);
		test_full_queue();
		idle_en = 1'b0;
		test_random_mix(400, 50, 40);

		req_ch.valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (n_mismatch == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
